// ===== design/matrix_vector_transform_unit_assert.svh =====
// ----------------------------------------------------------------------------
// matrix vector transform unit assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

// condition holds at every edge
`define MVT_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition implies a consequence at the same edge
`define MVT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies a consequence at the next edge
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// shared types and constants of the matrix vector transform unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int WORD_BITS     = 32;
  localparam int DIM           = 4;
  localparam int ENTRIES       = DIM * DIM;
  localparam int INDEX_BITS    = 4;
  localparam int IN_FIELD_BITS = INDEX_BITS + (DIM + 1) * WORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = DIM * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t [DIM-1:0]             vec_t;
  typedef word_t [ENTRIES-1:0]         mat_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                  en;
    logic [INDEX_BITS-1:0] index;
    word_t                 value;
  } entry_wr_t;

endpackage

// ===== design/mvt_matrix_store.sv =====
// ----------------------------------------------------------------------------
// mvt_matrix_store
// sixteen row-major matrix entries, cleared at reset, one write per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvt_matrix_store (
  input  logic              clk,
  input  logic              rst,
  input  mvt_pkg::entry_wr_t wr,
  output mvt_pkg::mat_t     entries
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (wr.en) begin
      entries[wr.index] <= wr.value;
    end
  end

endmodule

// ===== design/mvt_mult_stage.sv =====
// ----------------------------------------------------------------------------
// mvt_mult_stage
// sixteen parallel signed products, scaled down by the fraction bits, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvt_mult_stage #(
  parameter  int FRAC_BITS = 16,
  localparam int PROD_BITS = 2 * mvt_pkg::WORD_BITS - FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mvt_pkg::vec_t               vec,
  input  mvt_pkg::mat_t               entries,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [PROD_BITS-1:0] prod [mvt_pkg::ENTRIES]
);

  localparam int FULL_BITS = 2 * mvt_pkg::WORD_BITS;

  logic signed [FULL_BITS-1:0] full [mvt_pkg::ENTRIES];

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        full[r * mvt_pkg::DIM + c] = FULL_BITS'(entries[r * mvt_pkg::DIM + c])
                                   * FULL_BITS'(vec[c]);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // arithmetic shift right by the fraction bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < mvt_pkg::ENTRIES; i++) begin
        prod[i] <= full[i][FULL_BITS-1:FRAC_BITS];
      end
    end
  end

endmodule

// ===== design/mvt_row_adder.sv =====
// ----------------------------------------------------------------------------
// mvt_row_adder
// registered adder tree over each row of products, then saturation to a word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvt_row_adder #(
  parameter  int FRAC_BITS = 16,
  localparam int PROD_BITS = 2 * mvt_pkg::WORD_BITS - FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [PROD_BITS-1:0] prod [mvt_pkg::ENTRIES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output mvt_pkg::vec_t               result
);

  localparam int PAIR_BITS = PROD_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int PAIRS     = mvt_pkg::ENTRIES / 2;
  localparam int WB        = mvt_pkg::WORD_BITS;

  logic                        pair_valid;
  logic                        sum_valid;
  logic                        out_rdy;
  logic                        sum_rdy;
  logic signed [PAIR_BITS-1:0] pair [PAIRS];
  logic signed [SUM_BITS-1:0]  row_sum [mvt_pkg::DIM];
  mvt_pkg::vec_t               sat;

  assign out_rdy  = !out_valid || out_ready;
  assign sum_rdy  = !sum_valid || out_rdy;
  assign in_ready = !pair_valid || sum_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_valid <= in_valid;
      end
      if (sum_rdy) begin
        sum_valid <= pair_valid;
      end
      if (out_rdy) begin
        out_valid <= sum_valid;
      end
    end
  end

  // first level, two products per row half
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < PAIRS; i++) begin
        pair[i] <= PAIR_BITS'(prod[2 * i]) + PAIR_BITS'(prod[2 * i + 1]);
      end
    end
  end

  // second level, full row sums
  always_ff @(posedge clk) begin
    if (pair_valid && sum_rdy) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        row_sum[r] <= SUM_BITS'(pair[2 * r]) + SUM_BITS'(pair[2 * r + 1]);
      end
    end
  end

  // clamp to the signed word range
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      if ((&row_sum[r][SUM_BITS-1:WB-1]) || !(|row_sum[r][SUM_BITS-1:WB-1])) begin
        sat[r] = row_sum[r][WB-1:0];
      end else if (row_sum[r][SUM_BITS-1]) begin
        sat[r] = mvt_pkg::WORD_MIN;
      end else begin
        sat[r] = mvt_pkg::WORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && out_rdy) begin
      result <= sat;
    end
  end

endmodule

// ===== design/matrix_vector_transform_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_unit
// 4x4 signed fixed point matrix times 4-vector, fully pipelined
//
//   channel   direction  payload
//   s_axis    in         tuser opcode, tdata index, entry value, x y z w
//   m_axis    out        tdata out x y z w
//
// one item per cycle sustained while the output is not stalled, loads and transforms alike
// a transform result reaches m_axis through the input register, multiplier bank,
// two adder levels and clamp register
// a load takes effect for every transform accepted after it
// reset clears the matrix to zeros and empties the pipeline
// each stage stalls only when the one after it is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, entry_value, vec_x, vec_y, vec_z, vec_w, zero pad
  input  logic [mvt_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // opcode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [mvt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int PROD_BITS = 2 * mvt_pkg::WORD_BITS - FRAC_BITS;
  localparam int VEC_LO    = mvt_pkg::INDEX_BITS + mvt_pkg::WORD_BITS;

  mvt_pkg::opcode_t           opcode;
  mvt_pkg::vec_t              in_vec;
  mvt_pkg::entry_wr_t         wr;
  mvt_pkg::mat_t              entries;
  mvt_pkg::vec_t              stage_vec;
  mvt_pkg::vec_t              result;
  logic                       stage_valid;
  logic                       in_xfer;
  logic                       mult_ready;
  logic                       mult_valid;
  logic                       add_ready;
  logic signed [PROD_BITS-1:0] prod [mvt_pkg::ENTRIES];

  assign opcode  = mvt_pkg::opcode_t'(s_axis_tuser);
  assign in_vec  = s_axis_tdata[mvt_pkg::IN_FIELD_BITS-1:VEC_LO];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign wr.en    = in_xfer && (opcode == mvt_pkg::OP_LOAD);
  assign wr.index = s_axis_tdata[mvt_pkg::INDEX_BITS-1:0];
  assign wr.value = s_axis_tdata[VEC_LO-1:mvt_pkg::INDEX_BITS];

  assign s_axis_tready = !stage_valid || mult_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid && (opcode == mvt_pkg::OP_XFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (opcode == mvt_pkg::OP_XFORM)) begin
      stage_vec <= in_vec;
    end
  end

  mvt_matrix_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .entries (entries)
  );

  mvt_mult_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid),
    .in_ready  (mult_ready),
    .vec       (stage_vec),
    .entries   (entries),
    .out_valid (mult_valid),
    .out_ready (add_ready),
    .prod      (prod)
  );

  mvt_row_adder #(
    .FRAC_BITS (FRAC_BITS)
  ) u_add (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mult_valid),
    .in_ready  (add_ready),
    .prod      (prod),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  assign m_axis_tdata = result;

endmodule

// ===== design/mvt_port_checker.sv =====
// ----------------------------------------------------------------------------
// mvt_port_checker
// port level checks of the matrix vector transform unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_vector_transform_unit_assert.svh"

module mvt_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mvt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam logic [2:0] STAGES = 3'd5;

  logic [2:0] pending;
  logic       xform_in;
  logic       result_out;

  assign xform_in   = s_axis_tvalid && s_axis_tready
                   && (mvt_pkg::opcode_t'(s_axis_tuser) == mvt_pkg::OP_XFORM);
  assign result_out = m_axis_tvalid && m_axis_tready;

  // transforms inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(xform_in) - 3'(result_out);
    end
  end

  `MVT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  `MVT_ASSERT_IMPLY(a_no_phantom, m_axis_tvalid, pending != 3'd0, "result without a transform")
  `MVT_ASSERT_HOLDS(a_depth, pending <= STAGES, "more transforms in flight than stages")
  `MVT_ASSERT_IMPLY(a_room_ready, pending < STAGES, s_axis_tready, "input blocked with a free stage")

endmodule

bind matrix_vector_transform_unit mvt_port_checker u_port_checker (.*);

// ===== tb/matrix_vector_transform_checker.sv =====
// ----------------------------------------------------------------------------
// matrix vector transform checker
// watches both stream channels of the transform unit, keeps its own copy of
// the matrix, predicts each transform result in exact wide arithmetic with
// saturation, and compares every output transfer row by row in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_transform_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [mvt_pkg::IN_DATA_BITS-1:0]  in_data,
  input  logic                              in_user,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [mvt_pkg::OUT_DATA_BITS-1:0] out_data,
  output int                                fail_count,
  output int                                pending_results,
  output int                                checked_results,
  output int                                saturated_rows
);

  import mvt_pkg::*;

  localparam int VEC_LSB = INDEX_BITS + WORD_BITS;

  mat_t  stored_matrix;
  vec_t  expected_rows[$];
  int    mismatches;
  int    checked;
  int    saturated;
  string row_names[DIM];

  initial row_names = '{"out_x", "out_y", "out_z", "out_w"};

  function automatic vec_t transform_vector(input mat_t m, input vec_t v);
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    vec_t               rows;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        prod = $signed(m[DIM*r+c]) * $signed(v[c]);
        acc  = acc + (prod >>> FRAC_BITS);
      end
      if (acc > $signed(WORD_MAX)) begin
        rows[r] = WORD_MAX;
        saturated++;
      end else if (acc < $signed(WORD_MIN)) begin
        rows[r] = WORD_MIN;
        saturated++;
      end else begin
        rows[r] = acc[WORD_BITS-1:0];
      end
    end
    return rows;
  endfunction

  always @(posedge clk) begin
    vec_t got;
    vec_t want;
    if (rst) begin
      stored_matrix = '0;
      expected_rows.delete();
      mismatches = 0;
      checked    = 0;
      saturated  = 0;
    end else begin
      // results first, so a transfer in this cycle cannot match itself
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_rows.size() == 0) begin
          $display("%0t: result transfer with none expected, expected nothing actual %h",
                   $time, got);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          checked++;
          for (int r = 0; r < DIM; r++) begin
            if (got[r] !== want[r]) begin
              $display("%0t: %s expected %h actual %h", $time, row_names[r], want[r], got[r]);
              mismatches++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (opcode_t'(in_user) == OP_LOAD) begin
          stored_matrix[in_data[INDEX_BITS-1:0]] = in_data[INDEX_BITS +: WORD_BITS];
        end else begin
          expected_rows.push_back(transform_vector(stored_matrix,
                                                   in_data[VEC_LSB +: DIM*WORD_BITS]));
        end
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_rows.size();
    checked_results <= checked;
    saturated_rows  <= saturated;
  end

endmodule

// ===== tb/matrix_vector_transform_unit_tb.sv =====
// ----------------------------------------------------------------------------
// matrix vector transform unit testbench
// loads matrix entries and streams vectors through the unit: a directed part
// for the zero matrix, identity, extreme values, saturation and rounding,
// then random matrix reloads followed by or mixed with runs of transforms, with bursty
// input, a stalling output, long output hold-offs and full drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_transform_unit_tb;

  import mvt_pkg::*;

  localparam int    FRAC_BITS    = 16;
  localparam int    RANDOM_ITEMS = 1625;
  localparam int    FLOOD_ITEMS  = 40;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    DRAIN_CYCLES = 16;
  localparam int    CYCLE_LIMIT  = 200000;
  localparam int    VALUE_LSB    = INDEX_BITS;
  localparam int    VEC_LSB      = INDEX_BITS + WORD_BITS;
  localparam word_t ONE          = word_t'(1 << FRAC_BITS);

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int fail_count;
  int pending_results;
  int checked_results;
  int saturated_rows;
  int cycle_count = 0;
  int hold_seq    = 0;
  int burst_left  = 0;
  int load_count  = 0;
  int xform_count = 0;

  always #5 clk = ~clk;

  matrix_vector_transform_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  matrix_vector_transform_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_data        (s_axis_tdata),
    .in_user        (s_axis_tuser),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (m_axis_tdata),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .checked_results(checked_results),
    .saturated_rows (saturated_rows)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = WORD_MAX;
      1: w = WORD_MIN;
      2: w = '0;
      3: w = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
      4, 5, 6: w = word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
      default: w = word_t'($urandom);
    endcase
    return w;
  endfunction

  function automatic vec_t make_vec(input word_t x, input word_t y, input word_t z,
                                    input word_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  function automatic vec_t junk_vec();
    return vec_t'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_fields(input logic [INDEX_BITS-1:0] idx,
                                                           input word_t value, input vec_t v);
    logic [IN_DATA_BITS-1:0] d;
    d = '0;
    d[INDEX_BITS-1:0]            = idx;
    d[VALUE_LSB +: WORD_BITS]    = value;
    d[VEC_LSB +: DIM*WORD_BITS]  = v;
    return d;
  endfunction

  task automatic idle_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'($urandom_range(0, 1));
    s_axis_tdata  <= pack_fields(4'($urandom), word_t'($urandom), junk_vec());
    repeat (cycles) @(posedge clk);
  endtask

  // bursts of random length, mostly with gaps of random length between them
  task automatic put_item(input opcode_t op, input logic [IN_DATA_BITS-1:0] data);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_LOAD) load_count++;
    else xform_count++;
  endtask

  task automatic send_load(input logic [INDEX_BITS-1:0] idx, input word_t value);
    put_item(OP_LOAD, pack_fields(idx, value, junk_vec()));
  endtask

  task automatic send_xform(input vec_t v);
    put_item(OP_XFORM, pack_fields(4'($urandom), word_t'($urandom), v));
  endtask

  function automatic vec_t rand_vec();
    vec_t v;
    for (int c = 0; c < DIM; c++) v[c] = rand_word();
    if ($urandom_range(0, 3) == 0) v[3] = ONE;
    return v;
  endfunction

  task automatic wait_drained();
    idle_sender(1);
    burst_left = 0;
    while (pending_results != 0) @(posedge clk);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic flood_during_hold();
    hold_seq   <= hold_seq + 1;
    burst_left = FLOOD_ITEMS;
    for (int i = 0; i < FLOOD_ITEMS; i++) send_xform(rand_vec());
  endtask

  initial begin
    int sent;
    int n_loads;
    int n_xforms;
    bit mid_drain_done;
    sent           = 0;
    mid_drain_done = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero matrix after reset
    send_xform(make_vec(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
    // identity, point transform
    for (int i = 0; i < DIM; i++) send_load(4'(DIM * i + i), ONE);
    send_xform(make_vec(ONE, -3 * ONE, 2 * ONE, ONE));
    // extreme entries, saturation both ways
    send_load(4'd0, WORD_MAX);
    send_load(4'd5, WORD_MIN);
    send_load(4'd10, word_t'(-1));
    send_load(4'd15, WORD_MIN);
    send_xform(make_vec(WORD_MAX, WORD_MIN, ONE, WORD_MIN));
    send_xform(make_vec(WORD_MIN, WORD_MAX, -ONE, WORD_MAX));
    // rounding toward minus infinity on the shifted products
    send_xform(make_vec(word_t'(1), word_t'(1), word_t'(1), word_t'(1)));
    send_xform(make_vec(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1)));
    // off-diagonal corners
    send_load(4'd3, word_t'(32'h7fff_0001));
    send_load(4'd12, -ONE);
    send_xform(make_vec(3 * ONE, word_t'(32'h0000_8000), word_t'(-5), WORD_MAX));
    send_load(4'd0, '0);
    send_xform(make_vec('0, '0, '0, '0));
    send_xform(make_vec(ONE, ONE, ONE, ONE));
    wait_drained();

    flood_during_hold();
    sent = FLOOD_ITEMS;
    while (sent < RANDOM_ITEMS) begin
      n_loads  = ($urandom_range(0, 5) == 0) ? ENTRIES : $urandom_range(0, 4);
      n_xforms = $urandom_range(1, 30);
      if ($urandom_range(0, 7) == 0) begin
        // loose mix of loads and transforms in any order
        for (int i = 0; i < n_loads + n_xforms; i++) begin
          if ($urandom_range(0, 1) != 0) send_load(4'($urandom), rand_word());
          else send_xform(rand_vec());
        end
      end else begin
        for (int i = 0; i < n_loads; i++) begin
          if (n_loads == ENTRIES) send_load(4'(i), rand_word());
          else send_load(4'($urandom), rand_word());
        end
        for (int i = 0; i < n_xforms; i++) send_xform(rand_vec());
      end
      sent += n_loads + n_xforms;
      if (!mid_drain_done && sent >= RANDOM_ITEMS / 2) begin
        mid_drain_done = 1;
        wait_drained();
        flood_during_hold();
        sent += FLOOD_ITEMS;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d entry loads and %0d transforms, %0d results checked",
             load_count, xform_count, checked_results);
    $display("%0d saturated rows, two long output hold-offs with the input stalled",
             saturated_rows);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // output stall patterns, each held for a window of random length
  initial begin
    int seen_hold;
    int window;
    int mode;
    int tick;
    seen_hold = 0;
    window    = 0;
    mode      = 0;
    tick      = 0;
    forever begin
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (window == 0) begin
          mode   = $urandom_range(0, 3);
          window = $urandom_range(8, 80);
        end
        window--;
        tick++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (tick % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

endmodule
